[rtl/rsf_pkg.sv]
// radial smoothstep falloff: shared types and constants
// register index codes, field widths and the fixed-point constants of the datapath
// no dependencies
package rsf_pkg;

	localparam int CFG_DATA_W = 21;
	localparam int CFG_IDX_W  = 2;
	localparam int CENTER_W   = 17;
	localparam int RINV_W     = 21;
	localparam int GAIN_W     = 16;
	localparam int SAMPLE_W   = 16;
	localparam int SG_W       = SAMPLE_W + GAIN_W;
	localparam int MASK_W     = 17;
	localparam int T_SHIFT    = 12;
	localparam int P_W        = SG_W + MASK_W + 1;
	localparam int ROUND_SH   = 28;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X     = 2'd0,
		REG_CENTER_Y     = 2'd1,
		REG_RADIUS_INV   = 2'd2,
		REG_GAIN         = 2'd3
	} reg_index_t;

	localparam logic signed [CENTER_W-1:0] CENTER_RESET = 17'sd32768;
	localparam logic [RINV_W-1:0]          RINV_RESET   = 21'd4096;
	localparam logic signed [GAIN_W-1:0]   GAIN_RESET   = 16'sd4096;

	// 1.0 in Q1.16 and 3.0 in Q2.16
	localparam logic [MASK_W-1:0] ONE_Q16   = 17'd65536;
	localparam logic [17:0]       THREE_Q16 = 18'd196608;

	localparam logic signed [P_W-1:0] ROUND_BIAS = 50'sd134217728;
	localparam int                    RES_W      = P_W - ROUND_SH;
	localparam logic signed [RES_W-1:0] SAT_HI   = 22'sd32767;
	localparam logic signed [RES_W-1:0] SAT_LO   = -22'sd32768;

endpackage

[rtl/radial_smoothstep_falloff.sv]
// radial smoothstep falloff mask on a streamed height field
// one pipelined module: distance, bit-per-stage square root, smoothstep and gain
// depends on rsf_pkg
//
// Usage
//   Input channel in_valid/in_ready carries pixel_x, pixel_y and a Q4.12 sample_in.
//   Output channel out_valid/out_ready carries the masked, saturated sample_out.
//   Every input transfer yields exactly one output transfer, in order.
//   Configuration: cfg_write with cfg_index selects centre x, centre y, reciprocal
//   radius or gain and loads cfg_data at that edge; write only while the pipe is empty.
//   Throughput: one item per clock while out_ready stays high.
//   Pipeline: the square root resolves one root bit per stage and is most of its depth.
//   Stall: when the output register holds an item that is not taken, the whole
//   pipeline freezes and in_ready drops in the same cycle; nothing is lost.
//   Reset: asynchronous, clears every stage valid bit and loads the register
//   defaults (centre 2048.0, reciprocal radius 1/256, gain 1.0).
module radial_smoothstep_falloff
	import rsf_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [COORD_BITS-1:0]      pixel_x,
	input  logic [COORD_BITS-1:0]      pixel_y,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] sample_out,
	input  logic                       cfg_write,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data
);

	localparam int DXW    = ((COORD_BITS + 5) > CENTER_W ? COORD_BITS + 5 : CENTER_W) + 1;
	localparam int SQ_W   = 2 * DXW - 1;
	localparam int ROOT_W = DXW + 4;
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int REM_W  = ROOT_W + 2;
	localparam int TP_W   = ROOT_W + RINV_W;

	// configuration registers
	logic signed [CENTER_W-1:0] center_x_q, center_y_q;
	logic [RINV_W-1:0]          rinv_q;
	logic signed [GAIN_W-1:0]   gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= CENTER_RESET;
			center_y_q <= CENTER_RESET;
			rinv_q     <= RINV_RESET;
			gain_q     <= GAIN_RESET;
		end else if (cfg_write) begin
			case (reg_index_t'(cfg_index))
				REG_CENTER_X:   center_x_q <= $signed(cfg_data[CENTER_W-1:0]);
				REG_CENTER_Y:   center_y_q <= $signed(cfg_data[CENTER_W-1:0]);
				REG_RADIUS_INV: rinv_q     <= cfg_data[RINV_W-1:0];
				REG_GAIN:       gain_q     <= $signed(cfg_data[GAIN_W-1:0]);
				default: ;
			endcase
		end
	end

	// global advance: only an untaken result in the output register holds the pipe
	logic adv;
	logic v_s1, v_s2, v_s3, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;

	assign adv      = !v_s10 || out_ready;
	assign in_ready = adv;

	// stage 1: offsets from centre in Q.4
	logic signed [DXW-1:0]      dx_s1, dy_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic signed [DXW-1:0]      dx_next, dy_next;

	assign dx_next = $signed({{(DXW-COORD_BITS-4){1'b0}}, pixel_x, 4'b0000})
		- {{(DXW-CENTER_W){center_x_q[CENTER_W-1]}}, center_x_q};
	assign dy_next = $signed({{(DXW-COORD_BITS-4){1'b0}}, pixel_y, 4'b0000})
		- {{(DXW-CENTER_W){center_y_q[CENTER_W-1]}}, center_y_q};

	// stage 2: squares, sample times gain
	logic [SQ_W-1:0]          sqx_s2, sqy_s2;
	logic signed [SG_W-1:0]   sg_s2;
	logic signed [2*DXW-1:0]  sqx_full, sqy_full;
	logic signed [SG_W-1:0]   sg_next;

	assign sqx_full = dx_s1 * dx_s1;
	assign sqy_full = dy_s1 * dy_s1;
	assign sg_next  = sample_s1 * gain_q;

	// stage 3: radicand in Q.16
	logic [RAD_W-1:0]       rad_s3;
	logic signed [SG_W-1:0] sg_s3;
	logic [SQ_W:0]          sum_sq;

	assign sum_sq = {1'b0, sqx_s2} + {1'b0, sqy_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1     <= dx_next;
			dy_s1     <= dy_next;
			sample_s1 <= sample_in;
			sqx_s2    <= sqx_full[SQ_W-1:0];
			sqy_s2    <= sqy_full[SQ_W-1:0];
			sg_s2     <= sg_next;
			rad_s3    <= {sum_sq, 8'h00};
			sg_s3     <= sg_s2;
		end
	end

	// stage 4: restoring square root, one root bit per stage; entry 0 is the feed
	logic [REM_W-1:0]       sqrt_rem_s4  [ROOT_W+1];
	logic [ROOT_W-1:0]      sqrt_root_s4 [ROOT_W+1];
	logic [RAD_W-1:0]       sqrt_rad_s4  [ROOT_W+1];
	logic signed [SG_W-1:0] sqrt_sg_s4   [ROOT_W+1];
	logic                   sqrt_v_s4    [ROOT_W+1];

	assign sqrt_rem_s4[0]  = '0;
	assign sqrt_root_s4[0] = '0;
	assign sqrt_rad_s4[0]  = rad_s3;
	assign sqrt_sg_s4[0]   = sg_s3;
	assign sqrt_v_s4[0]    = v_s3;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
		logic [REM_W-1:0] rem_sh, trial, diff;
		logic             ge;

		// remainder stays below 2^ROOT_W, so the top two bits drop safely
		assign rem_sh = {sqrt_rem_s4[k][REM_W-3:0], sqrt_rad_s4[k][RAD_W-1 -: 2]};
		assign trial  = {sqrt_root_s4[k], 2'b01};
		assign ge     = rem_sh >= trial;
		assign diff   = rem_sh - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sqrt_v_s4[k+1] <= 1'b0;
			end else if (adv) begin
				sqrt_v_s4[k+1] <= sqrt_v_s4[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sqrt_rem_s4[k+1]  <= ge ? diff : rem_sh;
				sqrt_root_s4[k+1] <= {sqrt_root_s4[k][ROOT_W-2:0], ge};
				sqrt_rad_s4[k+1]  <= {sqrt_rad_s4[k][RAD_W-3:0], 2'b00};
				sqrt_sg_s4[k+1]   <= sqrt_sg_s4[k];
			end
		end
	end

	// stage 5: distance times reciprocal radius
	logic [TP_W-1:0]        tprod_s5;
	logic signed [SG_W-1:0] sg_s5;
	logic [TP_W-1:0]        tprod_next;

	assign tprod_next = sqrt_root_s4[ROOT_W] * rinv_q;

	// stage 6: falloff a = max(1 - t, 0)
	logic [MASK_W-1:0]      a_s6;
	logic signed [SG_W-1:0] sg_s6;
	logic [MASK_W-1:0]      a_next;

	always_comb begin
		if (tprod_s5[TP_W-1:T_SHIFT+16] == '0) begin
			a_next = ONE_Q16 - {1'b0, tprod_s5[T_SHIFT+15:T_SHIFT]};
		end else begin
			a_next = '0;
		end
	end

	// stage 7: a squared and 3 - 2a
	logic [17:0]              a2_s7, f_s7;
	logic signed [SG_W-1:0]   sg_s7;
	logic [2*MASK_W-1:0]      asq;

	assign asq = a_s6 * a_s6;

	// stage 8: smoothstep
	logic [MASK_W-1:0]      s_s8;
	logic signed [SG_W-1:0] sg_s8;
	logic [35:0]            sm;

	assign sm = a2_s7 * f_s7;

	// stage 9: full product, stage 10: round and saturate
	logic signed [P_W-1:0]      p_s9;
	logic signed [SAMPLE_W-1:0] out_s10;
	logic signed [P_W-1:0]      p_full, rnd;
	logic signed [RES_W-1:0]    res;
	logic signed [SAMPLE_W-1:0] sat;

	assign p_full = sg_s8 * $signed({1'b0, s_s8});
	assign rnd    = p_s9 + ROUND_BIAS;
	assign res    = rnd[P_W-1:ROUND_SH];

	always_comb begin
		if (res > SAT_HI) begin
			sat = SAT_HI[SAMPLE_W-1:0];
		end else if (res < SAT_LO) begin
			sat = SAT_LO[SAMPLE_W-1:0];
		end else begin
			sat = res[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (adv) begin
			v_s5  <= sqrt_v_s4[ROOT_W];
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tprod_s5 <= tprod_next;
			sg_s5    <= sqrt_sg_s4[ROOT_W];
			a_s6     <= a_next;
			sg_s6    <= sg_s5;
			a2_s7    <= asq[2*MASK_W-1:16];
			f_s7     <= THREE_Q16 - {a_s6, 1'b0};
			sg_s7    <= sg_s6;
			s_s8     <= sm[32:16];
			sg_s8    <= sg_s7;
			p_s9     <= p_full;
			out_s10  <= sat;
		end
	end

	assign out_valid  = v_s10;
	assign sample_out = out_s10;

	// remainder of the finished root never exceeds twice the root
	a_sqrt_rem: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_v_s4[ROOT_W] |-> sqrt_rem_s4[ROOT_W] <= {1'b0, sqrt_root_s4[ROOT_W], 1'b0})
		else $error("square root remainder out of range");

	// falloff mask lies within 0..1
	a_mask_max: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 |-> a_s6 <= ONE_Q16)
		else $error("falloff mask above one");

	// zero reciprocal radius means no falloff
	a_no_falloff: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && rinv_q == '0) |-> a_s6 == ONE_Q16)
		else $error("mask not one with zero reciprocal radius");

	// smoothstep stays within 0..1
	a_smooth_max: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 |-> s_s8 <= ONE_Q16)
		else $error("smoothstep above one");

	// a frozen pipe keeps its items in stage 9 and in the output stage 10
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!adv && v_s9) |=> v_s9 && v_s10)
		else $error("item lost in stalled pipeline");

endmodule

[tb/sv/testbench.sv]
// testbench for radial_smoothstep_falloff: directed and random pixel streams checked
// against an in-bench prediction of the distance, smoothstep mask, gain and saturation
// depends on rsf_pkg and the radial_smoothstep_falloff rtl
module testbench
	import rsf_pkg::*;
();

	localparam int COORD_W    = 12;
	localparam int PIXEL_MAX  = (1 << COORD_W) - 1;
	localparam int LIMIT      = 200000;
	localparam int FLUSH_WAIT = 40;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	logic [COORD_W-1:0]         pixel_x;
	logic [COORD_W-1:0]         pixel_y;
	logic signed [SAMPLE_W-1:0] sample_in;
	logic                       out_valid;
	logic                       out_ready;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       cfg_write;
	reg_index_t                 cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;

	// settings as the predictor sees them
	logic signed [CENTER_W-1:0] centre_x_q4   = CENTER_RESET;
	logic signed [CENTER_W-1:0] centre_y_q4   = CENTER_RESET;
	logic [RINV_W-1:0]          radius_inv    = RINV_RESET;
	logic signed [GAIN_W-1:0]   height_gain   = GAIN_RESET;

	logic signed [SAMPLE_W-1:0] expected_heights[$];
	int                         mismatch_count = 0;
	int                         cycle_count    = 0;
	bit                         stall_free     = 1'b0;

	radial_smoothstep_falloff #(
		.COORD_BITS(COORD_W)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.sample_in (sample_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample_out(sample_out),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned root  = 0;
		longint unsigned probe = 64'h4000_0000_0000_0000;
		while (probe > v)
			probe = probe >> 2;
		while (probe != 0) begin
			if (v >= root + probe) begin
				v    = v - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	// sample scaled by the smoothstep mask and the gain, rounded and clamped
	function automatic logic signed [SAMPLE_W-1:0] masked_height(
		logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic signed [SAMPLE_W-1:0] smp);
		longint          dx, dy, distance, ratio, fall, fall_sq, shaped, prod, rounded;
		longint unsigned dist_sq;
		dx       = longint'({x, 4'b0000}) - longint'(centre_x_q4);
		dy       = longint'({y, 4'b0000}) - longint'(centre_y_q4);
		dist_sq  = longint'(dx * dx + dy * dy);
		distance = longint'(floor_sqrt(dist_sq << 8));
		ratio    = (distance * longint'(radius_inv)) >> 12;
		fall     = (ratio < 65536) ? 65536 - ratio : 0;
		fall_sq  = (fall * fall) >> 16;
		shaped   = (fall_sq * (196608 - 2 * fall)) >> 16;
		prod     = longint'(smp) * longint'(height_gain) * shaped;
		rounded  = (prod + (longint'(1) << 27)) >>> 28;
		if (rounded > 32767)
			rounded = 32767;
		if (rounded < -32768)
			rounded = -32768;
		return SAMPLE_W'(rounded);
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	always @(posedge clk)
		out_ready <= stall_free || ($urandom_range(0, 99) >= 27);

	// result checker: one transfer against the oldest prediction
	always @(posedge clk) begin
		logic signed [SAMPLE_W-1:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_heights.size() == 0) begin
				$error("sample_out: expected nothing, got %0d", sample_out);
				mismatch_count++;
			end else begin
				want = expected_heights.pop_front();
				if (sample_out !== want) begin
					$error("sample_out: expected %0d, got %0d", want, sample_out);
					mismatch_count++;
				end
			end
		end
	end

	task automatic send_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
		input logic signed [SAMPLE_W-1:0] smp);
		while (!stall_free && $urandom_range(0, 99) < 27) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		pixel_x   <= x;
		pixel_y   <= y;
		sample_in <= smp;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_heights.push_back(masked_height(x, y, smp));
	endtask

	task automatic drain_pipeline();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_heights.size() != 0);
	endtask

	// all four registers, written only once the pipe is empty
	task automatic configure(input logic signed [CENTER_W-1:0] cx,
		input logic signed [CENTER_W-1:0] cy, input logic [RINV_W-1:0] rinv,
		input logic signed [GAIN_W-1:0] g);
		drain_pipeline();
		cfg_write <= 1'b1;
		cfg_index <= REG_CENTER_X;
		cfg_data  <= {{(CFG_DATA_W-CENTER_W){cx[CENTER_W-1]}}, cx};
		@(posedge clk);
		cfg_index <= REG_CENTER_Y;
		cfg_data  <= {{(CFG_DATA_W-CENTER_W){cy[CENTER_W-1]}}, cy};
		@(posedge clk);
		cfg_index <= REG_RADIUS_INV;
		cfg_data  <= rinv;
		@(posedge clk);
		cfg_index <= REG_GAIN;
		cfg_data  <= {{(CFG_DATA_W-GAIN_W){g[GAIN_W-1]}}, g};
		@(posedge clk);
		cfg_write   <= 1'b0;
		centre_x_q4 = cx;
		centre_y_q4 = cy;
		radius_inv  = rinv;
		height_gain = g;
	endtask

	task automatic pick_random_settings();
		logic signed [CENTER_W-1:0] cx, cy;
		logic [RINV_W-1:0]          rinv;
		logic signed [GAIN_W-1:0]   g;
		if ($urandom_range(0, 7) == 0) begin
			cx = CENTER_W'($urandom);
			cy = CENTER_W'($urandom);
		end else begin
			cx = CENTER_W'($urandom_range(0, 65535));
			cy = CENTER_W'($urandom_range(0, 65535));
		end
		if ($urandom_range(0, 7) == 0)
			case ($urandom_range(0, 3))
				0: rinv = '0;
				1: rinv = 21'd1;
				2: rinv = 21'h1FFFFF;
				default: rinv = 21'd1048576;
			endcase
		else
			rinv = RINV_W'((1 << 20) / $urandom_range(1, 3000));
		if ($urandom_range(0, 3) == 0)
			g = GAIN_W'($urandom);
		else
			g = GAIN_W'(int'($urandom_range(0, 8192)) - 4096);
		configure(cx, cy, rinv, g);
	endtask

	function automatic logic [COORD_W-1:0] near_pixel(int centre_px, int reach);
		int v;
		v = centre_px + int'($urandom_range(0, 2 * reach)) - reach;
		if (v < 0)
			v = 0;
		if (v > PIXEL_MAX)
			v = PIXEL_MAX;
		return COORD_W'(v);
	endfunction

	// mostly pixels in a square around the falloff disc, where the mask takes fractional values
	task automatic send_random_pixel();
		int reach;
		logic [COORD_W-1:0] x, y;
		if (radius_inv == 0)
			reach = PIXEL_MAX;
		else
			reach = (1 << 20) / int'(radius_inv) + 2;
		if (reach > PIXEL_MAX)
			reach = PIXEL_MAX;
		if ($urandom_range(0, 99) < 65) begin
			x = near_pixel(int'(centre_x_q4) >>> 4, reach);
			y = near_pixel(int'(centre_y_q4) >>> 4, reach);
		end else begin
			x = COORD_W'($urandom);
			y = COORD_W'($urandom);
		end
		send_pixel(x, y, SAMPLE_W'($urandom));
	endtask

	task automatic test_reset_defaults();
		send_pixel(12'd2048, 12'd2048, 16'sh7FFF);
		send_pixel(12'd2048, 12'd2048, -16'sh8000);
		send_pixel(12'd0, 12'd0, 16'sd4096);
		send_pixel(12'd4095, 12'd4095, -16'sd4096);
		send_pixel(12'd2100, 12'd2000, 16'sd20000);
		send_pixel(12'd0, 12'd4095, 16'sd0);
	endtask

	// zero reciprocal radius gives a flat mask, so sample and gain alone drive the clamp
	task automatic test_saturation_without_falloff();
		configure(17'sd0, 17'sd0, 21'd0, -16'sh8000);
		send_pixel(12'd4095, 12'd4095, -16'sh8000);
		send_pixel(12'd0, 12'd0, 16'sh7FFF);
		configure(17'sd0, 17'sd0, 21'd0, 16'sh7FFF);
		send_pixel(12'd1, 12'd2, 16'sh7FFF);
		send_pixel(12'd0, 12'd0, 16'sd1);
	endtask

	task automatic test_extreme_settings();
		configure(-17'sd65536, 17'sd65535, 21'h1FFFFF, 16'sd4096);
		send_pixel(12'd0, 12'd0, 16'sd12000);
		send_pixel(12'd4095, 12'd4095, -16'sd12000);
		configure(17'sd65535, -17'sd65536, 21'd1, 16'sd4096);
		send_pixel(12'd0, 12'd4095, 16'sh7FFF);
		send_pixel(12'd4095, 12'd0, -16'sh8000);
		configure(17'sd32768, 17'sd32768, 21'h1FFFFF, 16'sh7FFF);
		send_pixel(12'd2048, 12'd2048, 16'sh7FFF);
		send_pixel(12'd2049, 12'd2048, 16'sh7FFF);
		// radius of one pixel: side neighbours sit on the edge of the disc, the diagonal one outside
		configure(17'sd1600, 17'sd1600, 21'd1048576, 16'sd4096);
		send_pixel(12'd100, 12'd100, 16'sd8191);
		send_pixel(12'd101, 12'd100, 16'sd8191);
		send_pixel(12'd100, 12'd101, -16'sd8191);
		send_pixel(12'd101, 12'd101, 16'sd8191);
	endtask

	task automatic test_random_settings();
		for (int phase = 0; phase < 7; phase++) begin
			pick_random_settings();
			repeat (125)
				send_random_pixel();
		end
	endtask

	task automatic test_unstalled_stream();
		stall_free = 1'b1;
		for (int phase = 0; phase < 2; phase++) begin
			pick_random_settings();
			repeat (140)
				send_random_pixel();
		end
		stall_free = 1'b0;
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		pixel_x   = '0;
		pixel_y   = '0;
		sample_in = '0;
		out_ready = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_CENTER_X;
		cfg_data  = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_saturation_without_falloff();
		test_extreme_settings();
		test_random_settings();
		test_unstalled_stream();
		drain_pipeline();
		repeat (FLUSH_WAIT) @(posedge clk);
		if (mismatch_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

[files.f]
rtl/rsf_pkg.sv
rtl/radial_smoothstep_falloff.sv
tb/sv/testbench.sv
